// File: hw/rtl/icr_pkg.sv
package icr_pkg;

   localparam int SLOT_W      = 8;
   localparam int FIELD_W     = 48;
   localparam int BUDGET_W    = 49;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_TDATA_W = 112;
   localparam int RSP_TDATA_W = 104;

   localparam int SLOT_COUNT_DEF = 256;
   localparam int BYTE_WIDTH_DEF = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_PRIMARY_BUDGET   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECONDARY_BUDGET = 2'd1;

   typedef enum logic [1:0] {
      DEC_REJECT    = 2'd0,
      DEC_PRIMARY   = 2'd1,
      DEC_SECONDARY = 2'd2
   } dec_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_RESERVE,
      ST_DONE
   } state_type;

endpackage

// File: hw/rtl/icr_ram.sv
module icr_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/interval_capacity_reservation.sv
// Greedy slot-interval reservation against a primary and a secondary per-slot byte budget.
// Each request beat names [start_slot, end_slot], a size and a cost, and yields one response
// beat with the decision (0 reject, 1 primary, 2 secondary) and the running peak occupancy of
// each tier. Occupancy of both tiers lives in two single-read, single-write memories of
// SLOT_COUNT entries, and every slot is visited one per cycle through their read ports: a
// request with slots inside the table runs a fit check over them (none when the primary
// budget is unlimited, else one or two), then a reserve pass unless it is rejected, then
// loads the response register and returns to idle, where the next request beat is taken;
// a request with zero size or cost or an empty interval goes straight to the response
// register. A held response register stalls that load until it is freed. Slots at
// or beyond SLOT_COUNT are ignored. After reset the block clears every slot of both
// memories and takes no request beat during that time; configuration writes are taken
// at any time but are meant for idle periods. A finished response is held in an output
// register, so a new request is accepted while the previous response still waits.
module interval_capacity_reservation #(
   parameter int SLOT_COUNT = icr_pkg::SLOT_COUNT_DEF,
   parameter int BYTE_WIDTH = icr_pkg::BYTE_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // start_slot[7:0], end_slot[15:8], size_bytes[63:16], benefit_cost[111:64]
   input  logic [icr_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // decision[1:0], primary_peak[49:2], secondary_peak[97:50], zero[103:98]
   output logic [icr_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [icr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [icr_pkg::BUDGET_W-1:0]      csr_data
);

   localparam int AW     = $clog2(SLOT_COUNT);
   localparam int SW     = icr_pkg::SLOT_W;
   localparam int FW     = icr_pkg::FIELD_W;
   localparam int BW     = icr_pkg::BUDGET_W;
   localparam int PW     = ((SW > AW) ? SW : AW) + 1;
   localparam int SUM_W  = ((BYTE_WIDTH > FW) ? BYTE_WIDTH : FW) + 1;
   localparam int CMP_W  = ((BYTE_WIDTH > BW) ? BYTE_WIDTH : BW) + 2;
   localparam logic [AW-1:0]    LAST_ADDR = AW'(SLOT_COUNT - 1);
   localparam logic [PW-1:0]    SLOTS_P   = PW'(SLOT_COUNT);
   localparam logic [BYTE_WIDTH-1:0] OCC_MAX = {BYTE_WIDTH{1'b1}};
   localparam logic [SUM_W-1:0] OCC_MAX_S = {{(SUM_W-BYTE_WIDTH){1'b0}}, OCC_MAX};
   localparam logic [SUM_W-1:0] FIELD_MAX_S = {{(SUM_W-FW){1'b0}}, {FW{1'b1}}};
   localparam int RSP_PAD = icr_pkg::RSP_TDATA_W - 2 - 2 * FW;

   // request fields
   logic [SW-1:0] req_start;
   logic [SW-1:0] req_end;
   logic [FW-1:0] req_size;
   logic [FW-1:0] req_cost;

   assign req_start = req_tdata[SW-1:0];
   assign req_end   = req_tdata[2*SW-1:SW];
   assign req_size  = req_tdata[2*SW+FW-1:2*SW];
   assign req_cost  = req_tdata[2*SW+2*FW-1:2*SW+FW];

   icr_pkg::state_type state_ff, state_in;

   logic [AW-1:0]         ptr_ff, ptr_in;
   logic [AW-1:0]         lo_ff, lo_in;
   logic [AW-1:0]         hi_ff, hi_in;
   logic [AW-1:0]         raddr_ff, raddr_in;
   logic [FW-1:0]         bytes_ff, bytes_in;
   logic                  tier_sec_ff, tier_sec_in;
   icr_pkg::dec_type      decision_ff, decision_in;
   logic                  issue_done_ff, issue_done_in;
   logic                  rvalid_ff, rvalid_in;
   logic                  rlast_ff, rlast_in;
   logic                  fail_ff, fail_in;
   logic [BYTE_WIDTH-1:0] p_peak_ff, p_peak_in;
   logic [BYTE_WIDTH-1:0] s_peak_ff, s_peak_in;
   logic [BW-1:0]         p_budget_ff, p_budget_in;
   logic [BW-1:0]         s_budget_ff, s_budget_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   icr_pkg::dec_type      rsp_dec_ff, rsp_dec_in;
   logic [FW-1:0]         rsp_p_peak_ff, rsp_p_peak_in;
   logic [FW-1:0]         rsp_s_peak_ff, rsp_s_peak_in;

   // memory ports
   logic                  p_wr_en, s_wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [BYTE_WIDTH-1:0] wr_data;
   logic [BYTE_WIDTH-1:0] p_rd_data, s_rd_data, rd_data;

   icr_ram #(.WIDTH(BYTE_WIDTH), .DEPTH(SLOT_COUNT)) u_primary_ram (
      .clock   (clock),
      .wr_en   (p_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (p_rd_data)
   );

   icr_ram #(.WIDTH(BYTE_WIDTH), .DEPTH(SLOT_COUNT)) u_secondary_ram (
      .clock   (clock),
      .wr_en   (s_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (s_rd_data)
   );

   // shared decode
   logic                  req_fire, out_free, live, empty;
   logic                  p_unlim, s_unlim, s_on, sec_retry;
   logic [PW-1:0]         lo_p, hi_p;
   logic [AW-1:0]         hi_clip;
   logic                  issue, last_rd, over, fit_fail;
   logic [BW-1:0]         budget_sel;
   logic signed [CMP_W-1:0] limit, occ_s;
   logic [SUM_W-1:0]      sum, p_peak_x, s_peak_x;
   logic [BYTE_WIDTH-1:0] sat_sum;

   assign req_tready = (state_ff == icr_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign live       = (req_size != '0) && (req_cost != '0);

   assign lo_p    = PW'(req_start);
   assign hi_p    = PW'(req_end);
   assign empty   = (lo_p > hi_p) || (lo_p >= SLOTS_P);
   assign hi_clip = (hi_p >= SLOTS_P) ? LAST_ADDR : hi_p[AW-1:0];

   assign p_unlim   = p_budget_ff[BW-1];
   assign s_unlim   = s_budget_ff[BW-1];
   assign s_on      = (s_budget_ff != '0);
   assign sec_retry = !tier_sec_ff && s_on;

   assign issue   = ((state_ff == icr_pkg::ST_CHECK) || (state_ff == icr_pkg::ST_RESERVE))
                    && !issue_done_ff;
   assign last_rd = rvalid_ff && rlast_ff;
   assign rd_data = tier_sec_ff ? s_rd_data : p_rd_data;

   assign budget_sel = tier_sec_ff ? s_budget_ff : p_budget_ff;
   assign limit = $signed({{(CMP_W-BW){budget_sel[BW-1]}}, budget_sel})
                - $signed({{(CMP_W-FW){1'b0}}, bytes_ff});
   assign occ_s    = $signed({{(CMP_W-BYTE_WIDTH){1'b0}}, rd_data});
   assign over     = occ_s > limit;
   assign fit_fail = fail_ff || (rvalid_ff && over);

   assign sum = {{(SUM_W-BYTE_WIDTH){1'b0}}, rd_data} + {{(SUM_W-FW){1'b0}}, bytes_ff};
   assign sat_sum = (sum > OCC_MAX_S) ? OCC_MAX : sum[BYTE_WIDTH-1:0];

   assign p_peak_x = {{(SUM_W-BYTE_WIDTH){1'b0}}, p_peak_ff};
   assign s_peak_x = {{(SUM_W-BYTE_WIDTH){1'b0}}, s_peak_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         icr_pkg::ST_CLEAR: begin
            if (ptr_ff == LAST_ADDR) begin
               state_in = icr_pkg::ST_IDLE;
            end
         end
         icr_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (!live || empty) begin
                  state_in = icr_pkg::ST_DONE;
               end else if (p_unlim) begin
                  state_in = icr_pkg::ST_RESERVE;
               end else begin
                  state_in = icr_pkg::ST_CHECK;
               end
            end
         end
         icr_pkg::ST_CHECK: begin
            if (last_rd) begin
               if (!fit_fail) begin
                  state_in = icr_pkg::ST_RESERVE;
               end else if (sec_retry) begin
                  state_in = s_unlim ? icr_pkg::ST_RESERVE : icr_pkg::ST_CHECK;
               end else begin
                  state_in = icr_pkg::ST_DONE;
               end
            end
         end
         icr_pkg::ST_RESERVE: begin
            if (last_rd) begin
               state_in = icr_pkg::ST_DONE;
            end
         end
         icr_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = icr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = icr_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      ptr_in        = ptr_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      raddr_in      = raddr_ff;
      bytes_in      = bytes_ff;
      tier_sec_in   = tier_sec_ff;
      decision_in   = decision_ff;
      issue_done_in = issue_done_ff;
      rvalid_in     = 1'b0;
      rlast_in      = 1'b0;
      fail_in       = fail_ff;
      p_peak_in     = p_peak_ff;
      s_peak_in     = s_peak_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_dec_in    = rsp_dec_ff;
      rsp_p_peak_in = rsp_p_peak_ff;
      rsp_s_peak_in = rsp_s_peak_ff;
      p_wr_en       = 1'b0;
      s_wr_en       = 1'b0;
      wr_addr       = raddr_ff;
      wr_data       = sat_sum;
      rd_en         = issue;
      rd_addr       = ptr_ff;

      if (issue) begin
         rvalid_in     = 1'b1;
         rlast_in      = (ptr_ff == hi_ff);
         raddr_in      = ptr_ff;
         ptr_in        = ptr_ff + AW'(1);
         issue_done_in = (ptr_ff == hi_ff);
      end

      case (state_ff)
         icr_pkg::ST_CLEAR: begin
            p_wr_en = 1'b1;
            s_wr_en = 1'b1;
            wr_addr = ptr_ff;
            wr_data = '0;
            ptr_in  = ptr_ff + AW'(1);
         end
         icr_pkg::ST_IDLE: begin
            if (req_fire) begin
               lo_in         = lo_p[AW-1:0];
               hi_in         = hi_clip;
               ptr_in        = lo_p[AW-1:0];
               bytes_in      = req_size;
               tier_sec_in   = 1'b0;
               issue_done_in = 1'b0;
               fail_in       = 1'b0;
               decision_in   = live ? icr_pkg::DEC_PRIMARY : icr_pkg::DEC_REJECT;
            end
         end
         icr_pkg::ST_CHECK: begin
            fail_in = fit_fail;
            if (last_rd) begin
               ptr_in        = lo_ff;
               issue_done_in = 1'b0;
               fail_in       = 1'b0;
               if (fit_fail) begin
                  if (sec_retry) begin
                     tier_sec_in = 1'b1;
                     decision_in = icr_pkg::DEC_SECONDARY;
                  end else begin
                     decision_in = icr_pkg::DEC_REJECT;
                  end
               end
            end
         end
         icr_pkg::ST_RESERVE: begin
            if (rvalid_ff) begin
               if (tier_sec_ff) begin
                  s_wr_en = 1'b1;
                  if (sat_sum > s_peak_ff) begin
                     s_peak_in = sat_sum;
                  end
               end else begin
                  p_wr_en = 1'b1;
                  if (sat_sum > p_peak_ff) begin
                     p_peak_in = sat_sum;
                  end
               end
            end
         end
         icr_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_dec_in    = decision_ff;
               rsp_p_peak_in = (p_peak_x > FIELD_MAX_S) ? {FW{1'b1}} : p_peak_x[FW-1:0];
               rsp_s_peak_in = (s_peak_x > FIELD_MAX_S) ? {FW{1'b1}} : s_peak_x[FW-1:0];
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      p_budget_in = p_budget_ff;
      s_budget_in = s_budget_ff;
      if (csr_valid) begin
         case (csr_index)
            icr_pkg::CSR_PRIMARY_BUDGET:   p_budget_in = csr_data;
            icr_pkg::CSR_SECONDARY_BUDGET: s_budget_in = csr_data;
            default: begin
               p_budget_in = p_budget_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= icr_pkg::ST_CLEAR;
         ptr_ff        <= '0;
         rvalid_ff     <= 1'b0;
         rlast_ff      <= 1'b0;
         p_peak_ff     <= '0;
         s_peak_ff     <= '0;
         p_budget_ff   <= {BW{1'b1}};
         s_budget_ff   <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         rvalid_ff     <= rvalid_in;
         rlast_ff      <= rlast_in;
         p_peak_ff     <= p_peak_in;
         s_peak_ff     <= s_peak_in;
         p_budget_ff   <= p_budget_in;
         s_budget_ff   <= s_budget_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      raddr_ff      <= raddr_in;
      bytes_ff      <= bytes_in;
      tier_sec_ff   <= tier_sec_in;
      decision_ff   <= decision_in;
      issue_done_ff <= issue_done_in;
      fail_ff       <= fail_in;
      rsp_dec_ff    <= rsp_dec_in;
      rsp_p_peak_ff <= rsp_p_peak_in;
      rsp_s_peak_ff <= rsp_s_peak_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_s_peak_ff, rsp_p_peak_ff, rsp_dec_ff};

`ifndef SYNTHESIS
   a_no_same_addr_rmw: assert property (@(posedge clock) disable iff (reset)
      (rd_en && (p_wr_en || s_wr_en)) |-> (rd_addr != wr_addr))
      else $error("read and write hit the same slot in one cycle");

   a_read_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff |-> ((state_ff == icr_pkg::ST_CHECK) || (state_ff == icr_pkg::ST_RESERVE)))
      else $error("read data returned outside a scan");

   a_secondary_enabled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == icr_pkg::ST_DONE && out_free && decision_ff == icr_pkg::DEC_SECONDARY)
      |-> s_on)
      else $error("secondary decision with secondary tier disabled");

   a_peak_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((p_peak_ff >= $past(p_peak_ff)) && (s_peak_ff >= $past(s_peak_ff))))
      else $error("peak occupancy decreased");
`endif

endmodule
